/* src/go_back_n_window_sender_macros.svh */
// Assertion helpers for the go-back-n sender.
`ifndef GO_BACK_N_WINDOW_SENDER_MACROS_SVH
`define GO_BACK_N_WINDOW_SENDER_MACROS_SVH

// Check that prop holds in the same cycle whenever cond holds.
`define GBN_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("go-back-n sender: same-cycle check failed");

// Check that prop holds in the cycle after cond holds.
`define GBN_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("go-back-n sender: next-cycle check failed");

`endif

/* src/gbn_pkg.sv */
`timescale 1ns / 1ps

package gbn_pkg;

    // Default number of deadline entries.
    localparam int MAX_PACKETS_DEF = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_EXTENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_COUNT  = 2'd2;

    // Field widths.
    localparam int EXTENT_W = 5;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 6;
    localparam int SEQ5_W   = 5;

    // Register reset values.
    localparam logic [EXTENT_W-1:0] WINDOW_EXTENT_RST = 5'd3;
    localparam logic [TIME_W-1:0]   TIMEOUT_TICKS_RST = 32'd1000;
    localparam logic [COUNT_W-1:0]  PACKET_COUNT_RST  = 6'd20;

    typedef struct packed {
        logic              ack_valid;
        logic              ack_corrupt;
        logic [SEQ5_W-1:0] ack_seq;
        logic [TIME_W-1:0] now;
    } in_item_t;

    typedef struct packed {
        logic              send_valid;
        logic [SEQ5_W-1:0] send_seq;
        logic              is_retransmit;
        logic              all_done;
        logic              last;
    } out_item_t;

endpackage

/* src/gbn_ram.sv */
`timescale 1ns / 1ps

module gbn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // hold read data until the next read
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/go_back_n_window_sender.sv */
// Go-back-N window sender. Each input word is one pass of the sender loop: the current time
// and an optional cumulative ACK. A valid, uncorrupted ACK with base <= ack_seq < next
// sequence moves the window base to ack_seq + 1; then every in-flight packet in the window
// whose deadline is strictly before now is retransmitted in ascending order, and new packets
// are sent up to base + window_extent, clipped to packet_count (and to MAX_PACKETS). Each
// send stores now + timeout_ticks as the packet's deadline. One output word comes out per
// send, or one status word with send_valid low when nothing is sent; last marks the final
// word of a pass and all_done is the same on every word of the pass. Steps of a pass: the
// input word is accepted, then each in-flight window entry is checked in turn (the deadline
// memory has a single read port and is scanned one entry per cycle while no retransmit waits
// on a stalled output), then each new packet is sent, the send phase ends, and a closing step
// emits the last word; any output stall lengthens the pass. A pass that finds the transfer
// finished goes straight from acceptance to the closing step. The deadline memory needs no
// clearing after reset: only entries of packets already sent are ever read. The next input
// word is taken while the closing word of the previous pass still waits at the output.
`timescale 1ns / 1ps
`include "go_back_n_window_sender_macros.svh"

module go_back_n_window_sender import gbn_pkg::*; #(
    parameter int MAX_PACKETS = MAX_PACKETS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // sequence numbers run 0..MAX_PACKETS; compares use a wider common width
    localparam int SEQ_W = $clog2(MAX_PACKETS + 1);
    localparam int AW    = $clog2(MAX_PACKETS);
    localparam int CW    = SEQ_W + 6;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_SEND  = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    // configuration registers
    logic [EXTENT_W-1:0] extent_reg;
    logic [TIME_W-1:0]   timeout_reg;
    logic [COUNT_W-1:0]  count_reg;

    // sequencer state
    logic [1:0]        state_reg,      state_next;
    logic [SEQ_W-1:0]  base_reg,       base_next;
    logic [SEQ_W-1:0]  nseq_reg,       nseq_next;
    logic [SEQ_W-1:0]  cursor_reg,     cursor_next;
    logic [TIME_W-1:0] now_reg,        now_next;
    logic              done_reg,       done_next;

    // one pending send word, held back until we know whether it closes the pass
    logic              pend_valid_reg, pend_valid_next;
    logic [SEQ5_W-1:0] pend_seq_reg,   pend_seq_next;
    logic              pend_retx_reg,  pend_retx_next;

    // output register
    logic              out_valid_reg,  out_valid_next;
    out_item_t         out_data_reg,   out_data_next;

    // deadline memory ports
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [TIME_W-1:0] rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [TIME_W-1:0] wr_data;

    // datapath helpers
    logic [CW-1:0]     base_cw;
    logic [CW-1:0]     nseq_cw;
    logic [CW-1:0]     limit_cw;
    logic [CW-1:0]     top_cw;
    logic [CW-1:0]     ack_cw;
    logic              ack_ok;
    logic [CW-1:0]     new_base_cw;
    logic [CW-1:0]     nxt_cw;
    logic              out_free;
    logic              can_emit;
    logic              hit;
    logic              emit;
    logic [SEQ5_W-1:0] emit_seq;
    logic              emit_retx;

    gbn_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_PACKETS)
    ) u_deadline_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extent_reg  <= WINDOW_EXTENT_RST;
            timeout_reg <= TIMEOUT_TICKS_RST;
            count_reg   <= PACKET_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_WINDOW_EXTENT: extent_reg  <= cfg_data[EXTENT_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_reg <= cfg_data[TIME_W-1:0];
                CFG_PACKET_COUNT:  count_reg   <= cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Limit is the packet count clipped to the memory depth; the window end is inclusive.
    assign base_cw  = CW'(base_reg);
    assign nseq_cw  = CW'(nseq_reg);
    assign limit_cw = (CW'(count_reg) > CW'(MAX_PACKETS)) ? CW'(MAX_PACKETS) : CW'(count_reg);
    assign top_cw   = base_cw + CW'(extent_reg);
    assign ack_cw   = CW'(in_data.ack_seq);
    assign ack_ok   = in_data.ack_valid && !in_data.ack_corrupt &&
                      (ack_cw >= base_cw) && (ack_cw < nseq_cw);
    assign new_base_cw = ack_ok ? (ack_cw + CW'(1)) : base_cw;
    assign nxt_cw   = CW'(cursor_reg) + CW'(1);

    // A new word may enter the pending slot once the slot is empty or can move out.
    assign out_free = !out_valid_reg || !out_stall;
    assign can_emit = !pend_valid_reg || out_free;
    assign hit      = now_reg > rd_data;

    // Every send stamps the same fresh deadline.
    assign wr_data  = now_reg + timeout_reg;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        nseq_next       = nseq_reg;
        cursor_next     = cursor_reg;
        now_next        = now_reg;
        done_next       = done_reg;
        pend_valid_next = pend_valid_reg;
        pend_seq_next   = pend_seq_reg;
        pend_retx_next  = pend_retx_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        emit            = 1'b0;
        emit_seq        = '0;
        emit_retx       = 1'b0;

        // drop the output word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next        = in_data.now;
                    pend_valid_next = 1'b0;
                    if (base_cw >= limit_cw)
                    begin
                        // transfer already finished: ignore the ACK, report status
                        done_next  = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        base_next   = new_base_cw[SEQ_W-1:0];
                        cursor_next = new_base_cw[SEQ_W-1:0];
                        done_next   = (new_base_cw >= limit_cw);
                        // the window end never falls below the base, so only the
                        // in-flight bound can end the scan before it starts
                        if (new_base_cw < nseq_cw)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = new_base_cw[AW-1:0];
                            state_next = ST_CHECK;
                        end
                        else
                        begin
                            state_next = ST_SEND;
                        end
                    end
                end
            end

            ST_CHECK:
            begin
                // read data holds the deadline of the entry at the cursor
                if (!hit || can_emit)
                begin
                    if (hit)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = cursor_reg[AW-1:0];
                        emit      = 1'b1;
                        emit_seq  = SEQ5_W'(cursor_reg);
                        emit_retx = 1'b1;
                    end
                    if ((nxt_cw < nseq_cw) && (nxt_cw <= top_cw))
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = nxt_cw[AW-1:0];
                        cursor_next = nxt_cw[SEQ_W-1:0];
                    end
                    else
                    begin
                        state_next = ST_SEND;
                    end
                end
            end

            ST_SEND:
            begin
                if ((nseq_cw < limit_cw) && (nseq_cw <= top_cw))
                begin
                    if (can_emit)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = nseq_reg[AW-1:0];
                        emit      = 1'b1;
                        emit_seq  = SEQ5_W'(nseq_reg);
                        emit_retx = 1'b0;
                        nseq_next = nseq_reg + SEQ_W'(1);
                    end
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                // close the pass: the pending send, or a status word if nothing went out
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.send_valid     = pend_valid_reg;
                    out_data_next.send_seq       = pend_valid_reg ? pend_seq_reg : '0;
                    out_data_next.is_retransmit  = pend_valid_reg && pend_retx_reg;
                    out_data_next.all_done       = done_reg;
                    out_data_next.last           = 1'b1;
                    pend_valid_next              = 1'b0;
                    state_next                   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // advance the pending word to the output as a non-final send
        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next              = 1'b1;
                out_data_next.send_valid    = 1'b1;
                out_data_next.send_seq      = pend_seq_reg;
                out_data_next.is_retransmit = pend_retx_reg;
                out_data_next.all_done      = done_reg;
                out_data_next.last          = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_seq_next   = emit_seq;
            pend_retx_next  = emit_retx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            base_reg       <= '0;
            nseq_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            nseq_reg       <= nseq_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg    <= cursor_next;
        now_reg       <= now_next;
        done_reg      <= done_next;
        pend_seq_reg  <= pend_seq_next;
        pend_retx_reg <= pend_retx_next;
        out_data_reg  <= out_data_next;
    end

    // The base only ever moves up to an acknowledged packet, so it never passes the next one.
    `GBN_ASSERT_IMPLY(a_base_le_next, clk, rst_n, 1'b1, base_reg <= nseq_reg)
    `GBN_ASSERT_IMPLY(a_nseq_in_range, clk, rst_n, 1'b1, CW'(nseq_reg) <= CW'(MAX_PACKETS))
    // A word that sends nothing is always the closing status word.
    `GBN_ASSERT_IMPLY(a_status_is_last, clk, rst_n, out_valid && !out_data.send_valid,
                      out_data.last)
    // Between passes nothing may linger in the pending slot.
    `GBN_ASSERT_IMPLY(a_idle_no_pending, clk, rst_n, state_reg == ST_IDLE, !pend_valid_reg)
    `GBN_ASSERT_NEXT(a_accept_starts_pass, clk, rst_n, in_valid && !in_stall,
                     state_reg != ST_IDLE)

endmodule
